// ----- rtl/core/mbcd_pkg.sv -----
`default_nettype none
package mbcd_pkg;

    localparam int unsigned OUT_LANES = 8;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned THR_W     = 16;
    localparam int unsigned ST_W      = 3;
    localparam int unsigned EV_W      = 3;
    localparam int unsigned CFG_IDX_W = 8;

    // lane state codes
    localparam logic [ST_W-1:0] ST_IDLE         = 3'd0;
    localparam logic [ST_W-1:0] ST_DEB_PRESS    = 3'd1;
    localparam logic [ST_W-1:0] ST_PRESSED      = 3'd2;
    localparam logic [ST_W-1:0] ST_WAIT_RELEASE = 3'd3;
    localparam logic [ST_W-1:0] ST_WAIT_DOUBLE  = 3'd4;
    localparam logic [ST_W-1:0] ST_LONG         = 3'd5;
    localparam logic [ST_W-1:0] ST_REL_DEB      = 3'd6;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE       = 3'd0;
    localparam logic [EV_W-1:0] EV_CLICK      = 3'd1;
    localparam logic [EV_W-1:0] EV_DOUBLE     = 3'd2;
    localparam logic [EV_W-1:0] EV_LONG_START = 3'd3;
    localparam logic [EV_W-1:0] EV_HOLD       = 3'd4;
    localparam logic [EV_W-1:0] EV_LONG_END   = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_REPEAT  = 8'd3;

    localparam logic [THR_W-1:0] RST_DEBOUNCE     = 16'd20;
    localparam logic [THR_W-1:0] RST_LONG_PRESS   = 16'd1000;
    localparam logic [THR_W-1:0] RST_DOUBLE_CLICK = 16'd300;
    localparam logic [THR_W-1:0] RST_HOLD_REPEAT  = 16'd500;

    typedef struct packed {
        logic [THR_W-1:0] debounce;
        logic [THR_W-1:0] hold_start;
        logic [THR_W-1:0] dbl_window;
        logic [THR_W-1:0] hold_repeat;
    } cfg_t;

    typedef struct packed {
        logic [EV_W-1:0] ev;
        logic            stable;
        logic [ST_W-1:0] state;
    } lane_res_t;

    typedef struct packed {
        logic [OUT_LANES*EV_W-1:0] events;
        logic [OUT_LANES-1:0]      stable_pressed;
        logic [OUT_LANES*ST_W-1:0] states;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/mbcd_lane.sv -----
`default_nettype none
module mbcd_lane (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic [mbcd_pkg::TIME_W-1:0]     now,
    input  wire logic                            raw,
    input  wire mbcd_pkg::cfg_t                  cfg,
    output mbcd_pkg::lane_res_t                  res
);
    import mbcd_pkg::*;

    logic [ST_W-1:0]   state_reg, state_next;
    logic              stable_reg, stable_next;
    logic              last_raw_reg;
    logic [1:0]        click_reg, click_next;
    logic [TIME_W-1:0] raw_time_reg, raw_time_next;
    logic [TIME_W-1:0] entry_time_reg, entry_time_next;
    logic [TIME_W-1:0] press_time_reg, press_time_next;
    logic [TIME_W-1:0] release_time_reg, release_time_next;
    logic [TIME_W-1:0] hold_time_reg, hold_time_next;
    logic [EV_W-1:0]   ev;

    logic [TIME_W-1:0] raw_age, entry_age, press_age, release_age, hold_age;
    logic              raw_settled, entry_deb, press_long, release_dbl, hold_due;

    // all ages wrap modulo 2^32
    assign raw_time_next = (raw != last_raw_reg) ? now : raw_time_reg;
    assign raw_age       = now - raw_time_next;
    assign entry_age     = now - entry_time_reg;
    assign press_age     = now - press_time_reg;
    assign release_age   = now - release_time_reg;
    assign hold_age      = now - hold_time_reg;

    assign raw_settled = raw_age     >= {{(TIME_W-THR_W){1'b0}}, cfg.debounce};
    assign entry_deb   = entry_age   >= {{(TIME_W-THR_W){1'b0}}, cfg.debounce};
    assign press_long  = press_age   >= {{(TIME_W-THR_W){1'b0}}, cfg.hold_start};
    assign release_dbl = release_age >= {{(TIME_W-THR_W){1'b0}}, cfg.dbl_window};
    assign hold_due    = hold_age    >= {{(TIME_W-THR_W){1'b0}}, cfg.hold_repeat};

    assign stable_next = raw_settled ? raw : stable_reg;

    always_comb begin
        state_next        = state_reg;
        click_next        = click_reg;
        entry_time_next   = entry_time_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        hold_time_next    = hold_time_reg;
        ev                = EV_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (stable_next) begin
                    state_next      = ST_DEB_PRESS;
                    entry_time_next = now;
                end
            end
            ST_DEB_PRESS: begin
                if (stable_next) begin
                    if (entry_deb) begin
                        state_next      = ST_PRESSED;
                        entry_time_next = now;
                        press_time_next = now;
                        if (click_reg == 2'd0) begin
                            click_next = 2'd1;
                        end
                    end
                end else begin
                    state_next      = ST_IDLE;
                    entry_time_next = now;
                    click_next      = 2'd0;
                end
            end
            ST_PRESSED: begin
                if (!stable_next) begin
                    state_next        = ST_REL_DEB;
                    entry_time_next   = now;
                    release_time_next = now;
                end else if (press_long) begin
                    state_next      = ST_LONG;
                    entry_time_next = now;
                    hold_time_next  = now;
                    ev              = EV_LONG_START;
                end
            end
            ST_WAIT_RELEASE: begin
                if (!stable_next) begin
                    entry_time_next = now;
                    if (!release_dbl) begin
                        state_next = ST_WAIT_DOUBLE;
                    end else begin
                        state_next = ST_IDLE;
                        ev         = EV_CLICK;
                        click_next = 2'd0;
                    end
                end
            end
            ST_WAIT_DOUBLE: begin
                if (release_dbl) begin
                    state_next      = ST_IDLE;
                    entry_time_next = now;
                    ev              = EV_CLICK;
                    click_next      = 2'd0;
                end else if (stable_next) begin
                    state_next      = ST_DEB_PRESS;
                    entry_time_next = now;
                    click_next      = 2'd2;
                end
            end
            ST_LONG: begin
                if (!stable_next) begin
                    state_next      = ST_REL_DEB;
                    entry_time_next = now;
                    ev              = EV_LONG_END;
                    hold_time_next  = '0;
                end else if (hold_due) begin
                    ev             = EV_HOLD;
                    hold_time_next = now;
                end
            end
            ST_REL_DEB: begin
                if (!stable_next) begin
                    if (entry_deb) begin
                        entry_time_next = now;
                        if (click_reg == 2'd2) begin
                            state_next = ST_IDLE;
                            ev         = EV_DOUBLE;
                            click_next = 2'd0;
                        end else begin
                            state_next = ST_WAIT_RELEASE;
                        end
                    end
                end else begin
                    state_next      = ST_PRESSED;
                    entry_time_next = now;
                end
            end
            default: begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            stable_reg       <= 1'b0;
            last_raw_reg     <= 1'b0;
            click_reg        <= 2'd0;
            raw_time_reg     <= '0;
            entry_time_reg   <= '0;
            press_time_reg   <= '0;
            release_time_reg <= '0;
            hold_time_reg    <= '0;
        end else if (en) begin
            state_reg        <= state_next;
            stable_reg       <= stable_next;
            last_raw_reg     <= raw;
            click_reg        <= click_next;
            raw_time_reg     <= raw_time_next;
            entry_time_reg   <= entry_time_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
            hold_time_reg    <= hold_time_next;
        end
    end

    assign res.ev     = ev;
    assign res.stable = stable_next;
    assign res.state  = state_next;

    a_long_start_enters_long: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev == EV_LONG_START) |-> (state_reg == ST_PRESSED && state_next == ST_LONG))
        else $error("long start without entering long press");

    a_hold_stays_long: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && ev == EV_HOLD) |=> (state_reg == ST_LONG && hold_time_reg == $past(now)))
        else $error("hold report left long press or missed its time stamp");

    a_double_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ev == EV_DOUBLE) |-> (state_next == ST_IDLE && click_next == 2'd0))
        else $error("double click did not return to idle");

endmodule
`default_nettype wire

// ----- rtl/core/mbcd_merge.sv -----
`default_nettype none
module mbcd_merge #(
    parameter int unsigned LANES = 8
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     push,
    input  wire mbcd_pkg::lane_res_t                      lane_res [LANES],
    output logic                                          in_ready,
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output mbcd_pkg::result_t                             out_res
);
    import mbcd_pkg::*;

    result_t merged;
    result_t main_reg, skid_reg;
    logic    main_valid_reg, skid_valid_reg;
    logic    pop;

    for (genvar i = 0; i < OUT_LANES; i++) begin : g_pack
        if (i < LANES) begin : g_lane
            assign merged.events[i*EV_W +: EV_W] = lane_res[i].ev;
            assign merged.stable_pressed[i]      = lane_res[i].stable;
            assign merged.states[i*ST_W +: ST_W] = lane_res[i].state;
        end else begin : g_absent
            assign merged.events[i*EV_W +: EV_W] = EV_NONE;
            assign merged.stable_pressed[i]      = 1'b0;
            assign merged.states[i*ST_W +: ST_W] = ST_IDLE;
        end
    end

    assign pop = main_valid_reg && out_ready;

    // two-entry output buffer: the skid entry takes a request while the head waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_reg <= merged;
            end else begin
                main_reg <= merged;
            end
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    a_skid_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with an empty head");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("request taken with both entries full");

    a_skid_refills_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && pop) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry lost on head drain");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> main_valid_reg)
        else $error("accepted request not presented");

endmodule
`default_nettype wire

// ----- rtl/core/multi_button_click_long_press_detector_unit.sv -----
`default_nettype none
// Eight-button debouncer and click / double-click / long-press classifier. One scan tick
// (timestamp plus raw pressed levels) is taken per request and yields exactly one result
// request, registered in the output buffer; while s_ready is high a tick can be accepted
// every cycle, since each button has its own lane whose compares against the four
// thresholds are combinational, and a two-entry output buffer keeps s_ready high while
// one result waits on m_ready. Thresholds are written through the cfg port (index 0
// debounce, 1 long press, 2 double click window, 3 hold repeat; other indexes are
// ignored); cfg_ready is always high and writes should only be made while no tick is in
// flight. Buttons at index 8 and above have no output bits and are not built.
module multi_button_click_long_press_detector_unit #(
    parameter int unsigned NUM_BUTTONS = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [mbcd_pkg::TIME_W-1:0]         s_now_ms,
    input  wire logic [mbcd_pkg::OUT_LANES-1:0]      s_raw_pressed,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [mbcd_pkg::OUT_LANES*mbcd_pkg::EV_W-1:0] m_events,
    output logic [mbcd_pkg::OUT_LANES-1:0]           m_stable_pressed,
    output logic [mbcd_pkg::OUT_LANES*mbcd_pkg::ST_W-1:0] m_states,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mbcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mbcd_pkg::THR_W-1:0]          cfg_data
);
    import mbcd_pkg::*;

    // lanes past the output width are not built; their output bits read as idle
    localparam int unsigned LANES = (NUM_BUTTONS < OUT_LANES) ? NUM_BUTTONS : OUT_LANES;

    cfg_t      cfg_reg;
    lane_res_t lane_res [LANES];
    result_t   out_res;
    logic      accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce    <= RST_DEBOUNCE;
            cfg_reg.hold_start  <= RST_LONG_PRESS;
            cfg_reg.dbl_window  <= RST_DOUBLE_CLICK;
            cfg_reg.hold_repeat <= RST_HOLD_REPEAT;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEBOUNCE:     cfg_reg.debounce    <= cfg_data;
                CFG_LONG_PRESS:   cfg_reg.hold_start  <= cfg_data;
                CFG_DOUBLE_CLICK: cfg_reg.dbl_window  <= cfg_data;
                CFG_HOLD_REPEAT:  cfg_reg.hold_repeat <= cfg_data;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign accept = s_valid && s_ready;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        mbcd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (accept),
            .now     (s_now_ms),
            .raw     (s_raw_pressed[i]),
            .cfg     (cfg_reg),
            .res     (lane_res[i])
        );
    end

    mbcd_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .lane_res  (lane_res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_events         = out_res.events;
    assign m_stable_pressed = out_res.stable_pressed;
    assign m_states         = out_res.states;

endmodule
`default_nettype wire
